@@ hw/rtl/psm_pkg.sv @@
package psm_pkg;

  // fixed-point format of the coordinate and randoms
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned VAL_W     = FRAC_BITS + 1;
  localparam int unsigned RAND_W    = FRAC_BITS;
  localparam int unsigned SHIFT_W   = 5;

  // square root pipeline
  localparam int unsigned ROOT_W         = FRAC_BITS;
  localparam int unsigned SQ_W           = 2 * FRAC_BITS;
  localparam int unsigned SQRT_PER_STAGE = 4;
  localparam int unsigned SQRT_STAGES    = FRAC_BITS / SQRT_PER_STAGE;

  // exponent and power formats
  localparam int unsigned PROD_W = FRAC_BITS + SHIFT_W;
  localparam int unsigned IP_W   = PROD_W - FRAC_BITS;
  localparam int unsigned EXP_W  = 32;
  localparam int unsigned POW_W  = EXP_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COARSE_SHIFT = 1'b0,
    REG_FINE_SHIFT   = 1'b1
  } psm_reg_e;

  localparam logic [SHIFT_W-1:0] COARSE_RESET = 5'd6;
  localparam logic [SHIFT_W-1:0] FINE_RESET   = 5'd10;

  // sideband carried alongside the step computation
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             add;
  } psm_side_t;

  // 2^(-2^-k) in q0.32, k = 0..32
  typedef logic [EXP_W-1:0] exp_rom_t [0:EXP_W];

  function automatic logic [63:0] isqrt64_f(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] bit_v;
    r   = '0;
    rem = x;
    for (int i = 0; i < 32; i++) begin
      bit_v = 64'(1) << (62 - 2 * i);
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r   = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic exp_rom_t exp2_rom_f();
    exp_rom_t rom;
    rom[0] = 32'h8000_0000;
    for (int k = 1; k <= EXP_W; k++) begin
      rom[k] = EXP_W'(isqrt64_f({rom[k-1], 32'h0000_0000}));
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP2_ROM = exp2_rom_f();

endpackage

@@ hw/rtl/psm_if.sv @@
interface psm_in_if;
  logic                          valid;
  logic                          ready;
  logic [psm_pkg::VAL_W-1:0]     sample_value;
  logic [psm_pkg::RAND_W-1:0]    step_rand;
  logic [psm_pkg::RAND_W-1:0]    direction_rand;

  modport source (output valid, sample_value, step_rand, direction_rand, input ready);
  modport sink   (input valid, sample_value, step_rand, direction_rand, output ready);
endinterface

interface psm_out_if;
  logic                      valid;
  logic                      ready;
  logic [psm_pkg::VAL_W-1:0] mutated_value;

  modport source (output valid, mutated_value, input ready);
  modport sink   (input valid, mutated_value, output ready);
endinterface

@@ hw/rtl/psm_isqrt.sv @@
module psm_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [psm_pkg::RAND_W-1:0] rand_i,
  input  psm_pkg::psm_side_t         side_i,
  output logic                       valid_o,
  output logic [psm_pkg::ROOT_W-1:0] root_o,
  output psm_pkg::psm_side_t         side_o
);
  import psm_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sq_state_t;

  // restoring square root, several result bits per stage
  function automatic sq_state_t sq_stage_f(input sq_state_t st, input int unsigned first);
    sq_state_t       nx;
    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] bit_v;
    nx = st;
    for (int unsigned j = 0; j < SQRT_PER_STAGE; j++) begin
      bit_v = SQ_W'(1) << (SQ_W - 2 - 2 * (first + j));
      trial = {1'b0, nx.root} + {1'b0, bit_v};
      if ({1'b0, nx.rem} >= trial) begin
        nx.rem  = nx.rem - trial[SQ_W-1:0];
        nx.root = (nx.root >> 1) + bit_v;
      end else begin
        nx.root = nx.root >> 1;
      end
    end
    return nx;
  endfunction

  sq_state_t              st_in  [SQRT_STAGES];
  sq_state_t              st_d   [SQRT_STAGES];
  sq_state_t              st_q   [SQRT_STAGES];
  psm_side_t              side_in[SQRT_STAGES];
  psm_side_t              side_q [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] valid_q;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign st_in[s]   = '{rem: {rand_i, {FRAC_BITS{1'b0}}}, root: '0};
      assign side_in[s] = side_i;
    end else begin : g_body
      assign st_in[s]   = st_q[s-1];
      assign side_in[s] = side_q[s-1];
    end
    assign st_d[s] = sq_stage_f(st_in[s], s * SQRT_PER_STAGE);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s]   <= st_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[SQRT_STAGES-1];
  assign root_o  = st_q[SQRT_STAGES-1].root[ROOT_W-1:0];
  assign side_o  = side_q[SQRT_STAGES-1];

endmodule

@@ hw/rtl/psm_exp2.sv @@
module psm_exp2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [psm_pkg::FRAC_BITS-1:0] frac_i,
  input  logic [psm_pkg::IP_W-1:0]      ip_i,
  input  psm_pkg::psm_side_t            side_i,
  output logic                          valid_o,
  output logic [psm_pkg::POW_W-1:0]     pow_o,
  output logic [psm_pkg::IP_W-1:0]      ip_o,
  output psm_pkg::psm_side_t            side_o
);
  import psm_pkg::*;

  localparam int unsigned PROD2_W = 2 * EXP_W;

  // unity marks an accumulator still at exactly 1.0
  typedef struct packed {
    logic [EXP_W-1:0]     acc;
    logic                 unity;
    logic [FRAC_BITS-1:0] frac;
    logic [IP_W-1:0]      ip;
    psm_side_t            side;
  } ex_stage_t;

  // one fraction bit of weight 2^-k: multiply by a rom constant, round to q0.32
  function automatic ex_stage_t ex_step_f(input ex_stage_t st, input int unsigned k);
    ex_stage_t          nx;
    logic [PROD2_W-1:0] prod;
    nx   = st;
    prod = {{EXP_W{1'b0}}, st.acc} * {{EXP_W{1'b0}}, EXP2_ROM[k]}
         + (PROD2_W'(1) << (EXP_W - 1));
    if (st.frac[FRAC_BITS-k]) begin
      if (st.unity) begin
        nx.acc   = EXP2_ROM[k];
        nx.unity = 1'b0;
      end else begin
        nx.acc = prod[PROD2_W-1:EXP_W];
      end
    end
    return nx;
  endfunction

  ex_stage_t            st_in[FRAC_BITS];
  ex_stage_t            st_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] valid_q;

  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign st_in[s] = '{acc: '0, unity: 1'b1, frac: frac_i, ip: ip_i, side: side_i};
    end else begin : g_body
      assign st_in[s] = st_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= ex_step_f(st_in[s], s + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[FRAC_BITS-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[FRAC_BITS-1];
  assign pow_o   = st_q[FRAC_BITS-1].unity ? (POW_W'(1) << EXP_W)
                                            : {1'b0, st_q[FRAC_BITS-1].acc};
  assign ip_o    = st_q[FRAC_BITS-1].ip;
  assign side_o  = st_q[FRAC_BITS-1].side;

endmodule

@@ hw/rtl/primary_sample_mutation.sv @@
// small-step mutation of one primary-sample coordinate, q1.24 fixed point
//
// in_i carries sample_value, step_rand and direction_rand; out_o returns
// mutated_value. both are valid/ready channels, an item moves on a clock edge
// with valid and ready high. the user must write coarse_shift and fine_shift
// through cfg_we_i / cfg_idx_i / cfg_data_i only while no item is in flight;
// the block itself does not enforce it.
//
// pipeline: 6 square root stages of 4 bits, 1 multiply, 24 exp2 stages of one
// fraction bit each, 1 shift/subtract stage, 1 output register.
// throughput: one item per cycle unless out_o stalls; the 24 chained constant
// multiplies of the exp2 ladder set the depth, every stage holds one item.
//
// reset clears all valid bits and loads coarse_shift = 6, fine_shift = 10.
// when out_o stalls, the result lands in a one-entry skid register; ready on
// in_i is low only while that skid entry is full, and the whole pipe freezes
// then without losing or repeating an item.
module primary_sample_mutation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psm_pkg::SHIFT_W-1:0]   cfg_data_i,
  psm_in_if.sink                        in_i,
  psm_out_if.source                     out_o
);
  import psm_pkg::*;

  localparam int unsigned SUM_W = VAL_W + 1;
  localparam logic [SUM_W-1:0] ONE_X = SUM_W'(1) << FRAC_BITS;
  localparam int unsigned DVSH_W = SHIFT_W + 1;

  // configuration registers
  logic [SHIFT_W-1:0] coarse_q;
  logic [SHIFT_W-1:0] fine_q;
  logic [SHIFT_W-1:0] d_shift;
  logic               step_on;

  // global advance: the pipe moves unless the skid entry is occupied
  logic en;

  // square root stage outputs
  psm_side_t         in_side;
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  psm_side_t         sq_side;

  // exponent product d * sqrt(u)
  logic              mul_valid_q;
  logic [PROD_W-1:0] mul_d;
  logic [PROD_W-1:0] mul_q;
  psm_side_t         mul_side_q;

  // exp2 ladder outputs
  logic             ex_valid;
  logic [POW_W-1:0] ex_pow;
  logic [IP_W-1:0]  ex_ip;
  psm_side_t        ex_side;

  // difference stage
  logic [POW_W-1:0] a_sh;
  logic [POW_W-1:0] b_val;
  logic [EXP_W-1:0] diff_d;
  logic             a_valid_q;
  logic [EXP_W-1:0] diff_q;
  psm_side_t        a_side_q;

  // final add/subtract with wrap
  logic [DVSH_W-1:0] dv_shift;
  logic [RAND_W-1:0] dv;
  logic [SUM_W-1:0]  val_x;
  logic [SUM_W-1:0]  dv_x;
  logic [SUM_W-1:0]  sum_x;
  logic [VAL_W-1:0]  res;

  // output register and skid entry
  logic             last_fire;
  logic             out_free;
  logic             ov_q;
  logic             sk_q;
  logic [VAL_W-1:0] out_val_q;
  logic [VAL_W-1:0] skid_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_q <= COARSE_RESET;
      fine_q   <= FINE_RESET;
    end else if (cfg_we_i) begin
      unique case (psm_reg_e'(cfg_idx_i))
        REG_COARSE_SHIFT: coarse_q <= cfg_data_i;
        REG_FINE_SHIFT:   fine_q   <= cfg_data_i;
        default:          coarse_q <= coarse_q;
      endcase
    end
  end

  // fine not above coarse means no step at all
  assign step_on = fine_q > coarse_q;
  assign d_shift = fine_q - coarse_q;

  assign en         = !sk_q;
  assign in_i.ready = en;

  // only the add/subtract decision of the direction random is kept
  assign in_side = '{value: in_i.sample_value, add: !in_i.direction_rand[RAND_W-1]};

  // s = floor(sqrt(u * 2^24))
  psm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .rand_i  (in_i.step_rand),
    .side_i  (in_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // e = d * s, integer part feeds the final shift, fraction feeds exp2
  assign mul_d = PROD_W'(d_shift) * PROD_W'(sq_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q      <= mul_d;
      mul_side_q <= sq_side;
    end
  end

  // 2^-frac in q0.32 (33 bits so that exactly 1.0 fits)
  psm_exp2 u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mul_valid_q),
    .frac_i  (mul_q[FRAC_BITS-1:0]),
    .ip_i    (mul_q[PROD_W-1:FRAC_BITS]),
    .side_i  (mul_side_q),
    .valid_o (ex_valid),
    .pow_o   (ex_pow),
    .ip_o    (ex_ip),
    .side_o  (ex_side)
  );

  // a = 2^-e, b = 2^-d, clamp the difference at zero
  always_comb begin
    a_sh   = ex_pow >> ex_ip;
    b_val  = POW_W'(1) << (EXP_W - int'(d_shift));
    diff_d = '0;
    if (step_on && (a_sh > b_val)) begin
      diff_d = EXP_W'(a_sh - b_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= ex_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q   <= diff_d;
      a_side_q <= ex_side;
    end
  end

  // dv = diff scaled down by 2^-coarse into q0.24, then wrap once into [0,1]
  always_comb begin
    dv_shift = DVSH_W'(coarse_q) + DVSH_W'(EXP_W - FRAC_BITS);
    dv       = RAND_W'(diff_q >> dv_shift);
    val_x    = SUM_W'(a_side_q.value);
    dv_x     = SUM_W'(dv);
    if (a_side_q.add) begin
      sum_x = val_x + dv_x;
      if (sum_x > ONE_X) begin
        sum_x = sum_x - ONE_X;
      end
    end else if (dv_x > val_x) begin
      sum_x = val_x + ONE_X - dv_x;
    end else begin
      sum_x = val_x - dv_x;
    end
    res = VAL_W'(sum_x);
  end

  // output register with a one-entry skid behind it
  assign last_fire = a_valid_q && en;
  assign out_free  = !ov_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sk_q <= 1'b0;
    end else if (out_free) begin
      if (sk_q) begin
        ov_q <= 1'b1;
        sk_q <= 1'b0;
      end else begin
        ov_q <= last_fire;
      end
    end else if (last_fire) begin
      sk_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_val_q <= sk_q ? skid_val_q : res;
    end else if (last_fire) begin
      skid_val_q <= res;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.mutated_value = out_val_q;

  // skid entry is only ever filled behind a held output item
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_q |-> ov_q)
    else $error("skid entry full while output register empty");

  // a result leaving the pipe into a stalled output must be parked
  a_stall_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready && last_fire) |=> sk_q)
    else $error("result dropped while output stalled");

  // a frozen pipe keeps its last stage
  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(a_valid_q) && $stable(diff_q)))
    else $error("last stage changed during freeze");

endmodule

@@ tb/primary_sample_mutation_test.sv @@
module primary_sample_mutation_test;
  import psm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 3;
  // pipe is 33 deep plus the skid entry, leave some margin
  localparam int SETTLE_CYCLES  = 50;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 200;
  localparam int NUM_PHASES     = 12;
  localparam int FIXED_PHASES   = 9;
  localparam int RANDOM_ITEMS   = 117;
  localparam int PRESSURE_PHASE = 7;
  localparam int REPORT_LIMIT   = 10;
  localparam int IDLE_PERCENT   = 31;

  localparam logic [VAL_W-1:0]  ONE_Q24  = VAL_W'(1) << FRAC_BITS;
  localparam logic [RAND_W-1:0] RAND_MAX = '1;
  localparam logic [RAND_W-1:0] HALF_Q24 = RAND_W'(1) << (FRAC_BITS - 1);

  // register settings walked through; phase 0 keeps the reset values
  localparam int unsigned COARSE_PLAN [FIXED_PHASES] = '{6, 0, 20, 0, 20, 0, 19, 3, 10};
  localparam int unsigned FINE_PLAN   [FIXED_PHASES] = '{10, 20, 0, 0, 20, 1, 20, 17, 11};

  typedef struct packed {
    logic [VAL_W-1:0]  sample;
    logic [RAND_W-1:0] step;
    logic [RAND_W-1:0] dir;
  } mutation_req_t;

  // predicts the mutated coordinate and checks results in order
  class mutation_scoreboard;
    logic [SHIFT_W-1:0] coarse;
    logic [SHIFT_W-1:0] fine;
    logic [63:0]        pow_rom [0:FRAC_BITS];
    logic [VAL_W-1:0]   predicted_values [$];
    int unsigned        items_seen;
    int unsigned        results_checked;
    int unsigned        errors;

    function new();
      coarse     = COARSE_RESET;
      fine       = FINE_RESET;
      // 2^(-2^-k) in q0.32, each entry the root of the one before
      pow_rom[0] = 64'(1) << 31;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        pow_rom[k] = int_sqrt(pow_rom[k-1] << 32);
      end
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] cand;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = r | (64'(1) << b);
        if (cand * cand <= x) r = cand;
      end
      return r;
    endfunction

    function logic [VAL_W-1:0] step_size(logic [RAND_W-1:0] u);
      logic [63:0]          root;
      logic [63:0]          expo;
      logic [63:0]          acc;
      logic [63:0]          a;
      logic [63:0]          b;
      logic [63:0]          diff;
      logic [95:0]          prod;
      logic [FRAC_BITS-1:0] frac;
      int unsigned          d;
      int unsigned          ip;
      if (fine <= coarse) return '0;
      d    = 32'(fine) - 32'(coarse);
      root = int_sqrt({16'b0, u, 24'b0});
      expo = d * root;
      ip   = 32'(expo >> FRAC_BITS);
      frac = expo[FRAC_BITS-1:0];
      acc  = 64'(1) << 32;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        if (frac[FRAC_BITS-k]) begin
          prod = acc * pow_rom[k] + (96'(1) << 31);
          acc  = prod[95:32];
        end
      end
      a    = acc >> ip;
      b    = 64'(1) << (32 - d);
      diff = (a > b) ? a - b : 64'(0);
      return VAL_W'(diff >> (coarse + 32 - FRAC_BITS));
    endfunction

    function void set_reg(psm_reg_e idx, logic [SHIFT_W-1:0] val);
      if (idx == REG_COARSE_SHIFT) coarse = val;
      else fine = val;
    endfunction

    function void note_item(mutation_req_t req);
      logic [VAL_W:0] v;
      logic [VAL_W:0] dv;
      logic [VAL_W:0] one;
      one = (VAL_W+1)'(ONE_Q24);
      v   = (VAL_W+1)'(req.sample);
      dv  = (VAL_W+1)'(step_size(req.step));
      if (!req.dir[RAND_W-1]) begin
        v = v + dv;
        if (v > one) v = v - one;
      end else if (dv > v) begin
        v = v + one - dv;
      end else begin
        v = v - dv;
      end
      predicted_values.push_back(v[VAL_W-1:0]);
      items_seen++;
    endfunction

    function void check_result(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (predicted_values.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result mutated_value=0x%07h", got);
        return;
      end
      want = predicted_values.pop_front();
      results_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d: mutated_value expected 0x%07h got 0x%07h",
                   results_checked, want, got);
      end
    endfunction

    function int unsigned pending();
      return predicted_values.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  psm_reg_e          cfg_idx;
  logic [SHIFT_W-1:0] cfg_data;

  psm_in_if  in_ch ();
  psm_out_if out_ch ();

  mutation_scoreboard sb = new();

  // flow control shared by the driving processes
  bit          pressure_phase;
  bit          steady_flow;
  int unsigned idle_cycles;
  int unsigned input_stall_cycles;
  int unsigned settings_used;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  primary_sample_mutation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // offer one item, idling first at random unless the flow is steady
  task automatic send_item(input mutation_req_t req);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_value   <= req.sample;
    in_ch.step_rand      <= req.step;
    in_ch.direction_rand <= req.dir;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // both registers in back-to-back cycles, only while the pipe is empty
  task automatic apply_setting(input int unsigned coarse, input int unsigned fine);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_COARSE_SHIFT;
    cfg_data <= SHIFT_W'(coarse);
    @(posedge clk_i);
    cfg_idx  <= REG_FINE_SHIFT;
    cfg_data <= SHIFT_W'(fine);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_reg(REG_COARSE_SHIFT, SHIFT_W'(coarse));
    sb.set_reg(REG_FINE_SHIFT, SHIFT_W'(fine));
    settings_used++;
  endtask

  // one edge first so the monitor has noted the last item sent
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic mutation_req_t random_request();
    mutation_req_t req;
    // sample: bias toward the wrap points, sometimes beyond 1.0
    case ($urandom_range(9))
      0: req.sample = '0;
      1: req.sample = ONE_Q24;
      2: req.sample = ONE_Q24 - VAL_W'($urandom_range(255));
      3: req.sample = VAL_W'($urandom_range(255));
      4: req.sample = VAL_W'($urandom);
      default: req.sample = VAL_W'($urandom_range(ONE_Q24));
    endcase
    case ($urandom_range(7))
      0: req.step = '0;
      1: req.step = RAND_MAX;
      default: req.step = RAND_W'($urandom);
    endcase
    case ($urandom_range(9))
      0: req.dir = HALF_Q24 - 1'b1;
      1: req.dir = HALF_Q24;
      default: req.dir = RAND_W'($urandom);
    endcase
    return req;
  endfunction

  // corners of the fields, wrap in both directions, 1.0 and above
  task automatic send_directed();
    send_item('{'0, '0, '0});
    send_item('{'0, '0, RAND_MAX});
    send_item('{ONE_Q24, '0, '0});
    send_item('{ONE_Q24, RAND_MAX, '0});
    send_item('{ONE_Q24, RAND_MAX, HALF_Q24});
    send_item('{'1, '0, '0});
    send_item('{'1, RAND_MAX, RAND_MAX});
    send_item('{25'h0800000, RAND_MAX, HALF_Q24 - 1'b1});
    send_item('{25'h0800000, '0, HALF_Q24});
    send_item('{25'h0FFFFFF, 24'h400000, '0});
    send_item('{25'h0000001, 24'h400000, RAND_MAX});
    send_item('{25'h0555555, 24'hAAAAAA, 24'h555555});
    send_item('{25'h0AAAAAA, 24'h555555, 24'hAAAAAA});
  endtask

  // result side: random stalls, one long hold-off in the pressure phase
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_phase && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (steady_flow) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // handshake monitor and watchdog on cycles with no traffic
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item('{in_ch.sample_value, in_ch.step_rand, in_ch.direction_rand});
      if (in_ch.valid && !in_ch.ready) input_stall_cycles++;
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.mutated_value);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // main stimulus
  initial begin : stimulus
    int unsigned coarse;
    int unsigned fine;
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_COARSE_SHIFT;
    cfg_data             <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.sample_value   <= '0;
    in_ch.step_rand      <= '0;
    in_ch.direction_rand <= '0;
    pressure_phase       <= 1'b0;
    steady_flow          <= 1'b0;
    idle_cycles          = 0;
    input_stall_cycles   = 0;
    settings_used        = 1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        if (p < FIXED_PHASES) begin
          coarse = COARSE_PLAN[p];
          fine   = FINE_PLAN[p];
        end else begin
          // random setting with a nonzero step
          coarse = $urandom_range(19);
          fine   = $urandom_range(20, coarse + 1);
        end
        apply_setting(coarse, fine);
      end
      if (p == PRESSURE_PHASE) begin
        pressure_phase <= 1'b1;
        steady_flow    <= 1'b1;
      end
      // directed corners at the reset setting and at the widest step range
      if (p < 2) send_directed();
      repeat (RANDOM_ITEMS) send_item(random_request());
      in_ch.valid <= 1'b0;
      wait_drained();
      pressure_phase <= 1'b0;
      steady_flow    <= 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("mutated %0d coordinates over %0d register settings, %0d results compared",
             sb.items_seen, settings_used, sb.results_checked);
    $display("input side held off for %0d cycles by output back-pressure",
             input_stall_cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d errors, %0d results never arrived", sb.errors, sb.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/psm_pkg.sv
hw/rtl/psm_if.sv
hw/rtl/psm_isqrt.sv
hw/rtl/psm_exp2.sv
hw/rtl/primary_sample_mutation.sv
tb/primary_sample_mutation_test.sv
